/* sv/sac_pkg.sv */
package sac_pkg;

  localparam int ADDR_BITS = 32;
  localparam int NUM_SETS  = 1024;
  localparam int SET_BITS  = $clog2(NUM_SETS);
  localparam int NUM_WAYS  = 8;
  localparam int WAY_BITS  = $clog2(NUM_WAYS);
  localparam int MIN_OFF   = 2;
  localparam int TAG_BITS  = ADDR_BITS - MIN_OFF;
  localparam int CFG_BITS  = 4;
  localparam int CFG_IDX_BITS = 2;
  localparam int SHIFT_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic [NUM_WAYS-1:0] valid;
    logic [NUM_WAYS-1:0] dirty;
    logic [WAY_BITS-1:0] oldest;
  } meta_t;

  typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tag_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

/* sv/set_assoc_fifo_writeback_cache_unit.sv */
// Tag and state controller of a set-associative write-back cache with FIFO
// replacement. The input channel (in_valid/in_stall) carries one access per
// transaction: in_is_store and a 32-bit in_address. The result channel
// (out_valid/out_stall) returns one transaction per access: out_hit and
// out_write_back (a dirty victim was evicted).
// The configuration port writes offset_bits (index 0), index_bits (1) and
// ways_in_use (2) with cfg_wr_en, cfg_index and cfg_wdata; write it only
// while no access is in flight.
// Timing: an access is accepted, its set row is read from the tag and state
// memories on that edge, and on the next edge the row is updated and the
// result is registered. No new access is taken while one is in the lookup
// state, since the single-port set memories are read, modified and written.
// After reset the block clears all 1024 sets of the state memory, one set
// per cycle, with in_stall high; configuration writes are taken then.
// A stalled result stays in the output register; a new access is taken
// only when that register is empty or is emptied on the same edge.
module set_assoc_fifo_writeback_cache_unit
  import sac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_is_store,
  input  logic [ADDR_BITS-1:0]    in_address,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic                    out_write_back,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata
);

  state_t state_r;
  logic [SET_BITS-1:0] clr_cnt_r;

  logic [2:0] offset_bits_r;
  logic [3:0] index_bits_r;
  logic [3:0] ways_in_use_r;

  meta_t    meta_mem [NUM_SETS];
  tag_row_t tag_mem  [NUM_SETS];
  meta_t    meta_rd_r;
  tag_row_t tag_rd_r;

  logic                is_store_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [SET_BITS-1:0] set_r;

  logic out_valid_r;
  logic out_hit_r;
  logic out_write_back_r;

  logic                  in_accept;
  logic [2:0]            off_eff;
  logic [3:0]            idx_eff;
  logic [SHIFT_BITS-1:0] tag_shift;
  logic [SET_BITS-1:0]   set_mask;
  logic [ADDR_BITS-1:0]  addr_sh_off;
  logic [ADDR_BITS-1:0]  addr_sh_tag;
  logic [SET_BITS-1:0]   in_set;
  logic [TAG_BITS-1:0]   in_tag;

  logic [3:0]          ways_eff;
  logic [NUM_WAYS-1:0] way_en;
  logic [NUM_WAYS-1:0] match;
  logic                hit;
  logic [WAY_BITS-1:0] hit_way;
  logic                any_free;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] victim;
  logic [WAY_BITS-1:0] fifo_way;
  logic [3:0]          fifo_inc;
  logic                wb;
  meta_t               meta_upd;
  tag_row_t            tag_upd;

  logic                meta_we;
  logic [SET_BITS-1:0] meta_waddr;
  meta_t               meta_wdata;
  logic                tag_we;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  // address split
  always_comb begin
    off_eff     = (offset_bits_r < 3'(MIN_OFF)) ? 3'(MIN_OFF) : offset_bits_r;
    idx_eff     = (index_bits_r > 4'(SET_BITS)) ? 4'(SET_BITS) : index_bits_r;
    tag_shift   = SHIFT_BITS'(off_eff) + SHIFT_BITS'(idx_eff);
    set_mask    = ~({SET_BITS{1'b1}} << idx_eff);
    addr_sh_off = in_address >> off_eff;
    addr_sh_tag = in_address >> tag_shift;
    in_set      = addr_sh_off[SET_BITS-1:0] & set_mask;
    in_tag      = addr_sh_tag[TAG_BITS-1:0];
  end

  // lookup and replacement
  always_comb begin
    ways_eff = ways_in_use_r;
    if (ways_in_use_r == 4'd0) begin
      ways_eff = 4'd1;
    end else if (ways_in_use_r > 4'(NUM_WAYS)) begin
      ways_eff = 4'(NUM_WAYS);
    end
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      way_en[w] = 4'(w) < ways_eff;
      match[w]  = way_en[w] && meta_rd_r.valid[w] && (tag_rd_r[w] == tag_r);
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (way_en[w] && !meta_rd_r.valid[w]) begin
        any_free = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    fifo_way = (4'(meta_rd_r.oldest) >= ways_eff) ? '0 : meta_rd_r.oldest;
    fifo_inc = 4'(fifo_way) + 4'd1;
    victim   = any_free ? free_way : fifo_way;
    wb       = !hit && !any_free && meta_rd_r.dirty[fifo_way];

    meta_upd = meta_rd_r;
    tag_upd  = tag_rd_r;
    if (hit) begin
      if (is_store_r) begin
        meta_upd.dirty[hit_way] = 1'b1;
      end
    end else begin
      meta_upd.valid[victim] = 1'b1;
      meta_upd.dirty[victim] = is_store_r;
      tag_upd[victim]        = tag_r;
      if (!any_free) begin
        meta_upd.oldest = (fifo_inc == ways_eff) ? '0 : fifo_inc[WAY_BITS-1:0];
      end
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = set_r;
    meta_wdata = meta_upd;
    tag_we     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt_r;
        meta_wdata = '0;
      end
      ST_LOOKUP: begin
        meta_we = 1'b1;
        tag_we  = !hit;
      end
      ST_IDLE: begin
        meta_we = 1'b0;
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  // set memories
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (in_accept) begin
      meta_rd_r <= meta_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[set_r] <= tag_upd;
    end
    if (in_accept) begin
      tag_rd_r <= tag_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      is_store_r <= in_is_store;
      tag_r      <= in_tag;
      set_r      <= in_set;
    end
    if (state_r == ST_LOOKUP) begin
      out_hit_r        <= hit;
      out_write_back_r <= wb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      offset_bits_r <= 3'd5;
      index_bits_r  <= 4'd10;
      ways_in_use_r <= 4'd1;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata[2:0];
          CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
          CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SET_BITS'(NUM_SETS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
      if (state_r == ST_LOOKUP) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_write_back = out_write_back_r;

endmodule

/* tb/set_assoc_fifo_writeback_cache_unit_tb.sv */
module set_assoc_fifo_writeback_cache_unit_tb;
  import sac_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 50;

  class cache_scoreboard;
    typedef struct packed {
      bit hit;
      bit write_back;
    } access_result_t;

    bit                 holds     [NUM_SETS][NUM_WAYS];
    bit                 dirty     [NUM_SETS][NUM_WAYS];
    bit [ADDR_BITS-1:0] line_tags [NUM_SETS][NUM_WAYS];
    bit [WAY_BITS-1:0]  fifo_ptr  [NUM_SETS];
    bit [CFG_BITS-1:0]  offset_cfg = 4'd5;
    bit [CFG_BITS-1:0]  index_cfg  = 4'd10;
    bit [CFG_BITS-1:0]  ways_cfg   = 4'd1;
    access_result_t     results_due[$];
    int                 errors = 0;

    function void write_cfg(bit [CFG_IDX_BITS-1:0] idx, bit [CFG_BITS-1:0] val);
      case (idx)
        CFG_OFFSET_BITS: offset_cfg = val & 4'd7;
        CFG_INDEX_BITS:  index_cfg = val;
        CFG_WAYS_IN_USE: ways_cfg = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void note_access(bit st, bit [ADDR_BITS-1:0] a);
      int off, idx, ways, set_no, victim;
      bit [ADDR_BITS-1:0] tag_val;
      access_result_t r;
      off = (offset_cfg < MIN_OFF) ? MIN_OFF : int'(offset_cfg);
      idx = (index_cfg > SET_BITS) ? SET_BITS : int'(index_cfg);
      ways = (ways_cfg == 0) ? 1 : ((ways_cfg > NUM_WAYS) ? NUM_WAYS : int'(ways_cfg));
      set_no = int'((a >> off) & ((32'd1 << idx) - 32'd1));
      tag_val = a >> (off + idx);
      r.hit = 1'b0;
      r.write_back = 1'b0;
      for (int w = 0; w < ways; w++) begin
        if (holds[set_no][w] && line_tags[set_no][w] == tag_val) begin
          if (st) dirty[set_no][w] = 1'b1;
          r.hit = 1'b1;
          results_due.push_back(r);
          return;
        end
      end
      victim = ways;
      for (int w = ways - 1; w >= 0; w--) begin
        if (!holds[set_no][w]) victim = w;
      end
      if (victim == ways) begin
        victim = int'(fifo_ptr[set_no]);
        if (victim >= ways) victim = 0;
        r.write_back = dirty[set_no][victim];
        fifo_ptr[set_no] = WAY_BITS'((victim + 1) % ways);
      end
      holds[set_no][victim] = 1'b1;
      line_tags[set_no][victim] = tag_val;
      dirty[set_no][victim] = st;
      results_due.push_back(r);
    endfunction

    function void check_result(bit hit, bit wb);
      access_result_t want;
      if (results_due.size() == 0) begin
        $error("result transaction with no access outstanding: hit %0d write_back %0d",
               hit, wb);
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (hit !== want.hit) begin
        $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
        errors++;
      end
      if (wb !== want.write_back) begin
        $error("write_back mismatch: expected %0d, actual %0d", want.write_back, wb);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_is_store;
  logic [ADDR_BITS-1:0]    in_address;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic                    out_write_back;
  logic                    cfg_wr_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  int idle_mode = 0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  int phase_off  [PHASES] = '{2, 7, 3, 4, 10, 6, 5, 1, 2, 7};
  int phase_idx  [PHASES] = '{0, 10, 2, 1, 3, 14, 4, 0, 1, 5};
  int phase_ways [PHASES] = '{8, 8, 4, 1, 2, 3, 9, 5, 7, 6};

  cache_scoreboard sb = new();

  set_assoc_fifo_writeback_cache_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_is_store    (in_is_store),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_write_back (out_write_back),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 9;
      1: return $urandom_range(99) < 85;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(99) < 85;
      1: return $urandom_range(99) < 9;
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_access(input bit st, input bit [ADDR_BITS-1:0] a);
    @(negedge clk);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_is_store <= st;
    in_address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_access(st, a);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_BITS'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_cfg(idx, CFG_BITS'(val));
  endtask

  task automatic configure(input int off, input int idx, input int ways);
    write_reg(CFG_OFFSET_BITS, off);
    write_reg(CFG_INDEX_BITS, idx);
    write_reg(CFG_WAYS_IN_USE, ways);
  endtask

  // receiver side: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_request = 1'b0;
      end
      out_stall <= receiver_idles();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_hit, out_write_back);
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    bit [ADDR_BITS-1:0] tag_pool[$];
    bit [ADDR_BITS-1:0] set_pool[3];
    bit [ADDR_BITS-1:0] addr;
    int eo, ei, ways_eff;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_is_store = 1'b0;
    in_address  = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = CFG_OFFSET_BITS;
    cfg_wdata   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration, direct mapped
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_001F);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'h8000_0000);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFE0);
    send_access(1'b0, 32'h7FFF_FFE0);

    // offset below minimum, no index bits, zero ways
    drain();
    configure(0, 0, 0);
    send_access(1'b0, 32'h0000_0004);
    send_access(1'b0, 32'h0000_0007);
    send_access(1'b1, 32'h0000_0008);
    send_access(1'b0, 32'h0000_0004);

    // largest lines, saturated index and ways, fifo eviction in one set
    drain();
    configure(7, 15, 15);
    for (int t = 1; t <= 9; t++) send_access(1'b1, ADDR_BITS'(t) << 17);
    send_access(1'b0, 32'h1 << 17);
    send_access(1'b0, 32'hA << 17);

    // shrink ways with the pointer beyond the new range, lines kept
    drain();
    configure(7, 10, 2);
    send_access(1'b0, 32'hB << 17);
    send_access(1'b0, 32'h3 << 17);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      configure(phase_off[p], phase_idx[p], phase_ways[p]);
      idle_mode = (p < 3) ? 0 : ((p < 6) ? 1 : 2);
      eo = phase_off[p] & 7;
      if (eo < MIN_OFF) eo = MIN_OFF;
      ei = (phase_idx[p] > SET_BITS) ? SET_BITS : phase_idx[p];
      ways_eff = (phase_ways[p] > NUM_WAYS) ? NUM_WAYS : phase_ways[p];
      tag_pool.delete();
      for (int i = 0; i < ways_eff + 3; i++) tag_pool.push_back($urandom());
      for (int i = 0; i < 3; i++) set_pool[i] = $urandom() & ((32'd1 << ei) - 32'd1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 7 && n == 20) hold_request = 1'b1;
        if ($urandom_range(99) < 20) begin
          addr = $urandom();
        end else begin
          addr = (tag_pool[$urandom_range(tag_pool.size() - 1)] << (eo + ei))
               | (set_pool[$urandom_range(2)] << eo)
               | ($urandom() & ((32'd1 << eo) - 32'd1));
        end
        send_access(1'($urandom_range(1)), addr);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sac_pkg.sv
sv/set_assoc_fifo_writeback_cache_unit.sv
tb/set_assoc_fifo_writeback_cache_unit_tb.sv
